### hw/rtl/char_lcd_nibble_writer_unit_macros.svh
// Assertion macros shared by the character-LCD nibble writer.
`ifndef CHAR_LCD_NIBBLE_WRITER_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLN_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("cln assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define CLN_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("cln assertion failed: next-cycle implication");

`endif

### hw/rtl/cln_pkg.sv
package cln_pkg;

  // Request codes of the cmd field.
  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_CHAR = 2'd2;
  localparam logic [1:0] REQ_NUM  = 2'd3;

  localparam logic [7:0] CUR_HOME    = 8'h80;
  localparam logic [7:0] LCD_BASE_R1 = 8'h80;
  localparam logic [7:0] LCD_BASE_R2 = 8'hC0;
  localparam logic [7:0] LCD_BASE_R3 = 8'h94;
  localparam logic [7:0] LCD_BASE_R4 = 8'hD4;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ERR      = 8'h45;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [3:0] NIB_WAKE    = 4'h3;
  localparam logic [3:0] NIB_4BIT    = 4'h2;

  // Wake-up nibbles before the four-bit switch, and number of init bytes.
  localparam int WAKE_NIBS  = 3;
  localparam int INIT_BYTES = 5;
  // Double-dabble shifts for a 17-bit magnitude.
  localparam int DD_STEPS   = 17;
  localparam int MAG_W      = 17;
  localparam int BCD_W      = 20;
  localparam int MAX_DIGITS = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_INITNIB,
    ST_STEP,
    ST_HI,
    ST_LO,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    STP_INIT,
    STP_CMD,
    STP_CUR0,
    STP_CHAR,
    STP_NEGCUR,
    STP_NEGCH,
    STP_HOME,
    STP_DCUR,
    STP_DCH,
    STP_ECUR,
    STP_ECH,
    STP_DONE
  } step_t;

  typedef enum logic [2:0] {
    BSRC_INIT,
    BSRC_BYTE,
    BSRC_CURSOR,
    BSRC_HOME,
    BSRC_MINUS,
    BSRC_DIGIT,
    BSRC_ERR
  } bsrc_t;

  typedef enum logic [1:0] {
    NSEL_HI,
    NSEL_LO,
    NSEL_WAKE,
    NSEL_4BIT
  } nsel_t;

  typedef struct packed {
    logic       load_in;
    logic       dd_step;
    logic       load_byte;
    bsrc_t      bsrc;
    logic       byte_rs;
    logic [2:0] init_idx;
    logic       col_inc;
    logic       didx_dec;
    logic       push;
    nsel_t      nsel;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       row_ok;
    logic       home_cond;
    logic       neg;
    logic       didx_nz;
    logic       didx_one;
    logic       err_dc;
    logic       out_free;
    logic       hold_valid;
  } dp_sts_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h01;
      3'd2:    b = 8'h06;
      3'd3:    b = 8'h0E;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/cln_if.sv
interface cln_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  byte_value;
  logic [2:0]  row;
  logic [7:0]  column;
  logic signed [15:0] number;
  logic [3:0]  digit_count;

  modport source (output valid, cmd, byte_value, row, column, number, digit_count,
                  input ready);
  modport sink   (input valid, cmd, byte_value, row, column, number, digit_count,
                  output ready);
endinterface

interface cln_nib_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, reg_select, nibble, last, input ready);
  modport sink   (input valid, reg_select, nibble, last, output ready);
endinterface

### hw/rtl/char_lcd_nibble_writer_unit.sv
// Character-LCD nibble writer for a display on a 4-bit data bus.
// in_req carries one request per item (init, command byte, char at a position,
// or a decimal number at a position). out_nib carries the nibble transfers the
// request causes, one item per enable strobe, high nibble first, each with its
// register-select level; last marks the final nibble of a request.
// Requests are handled one at a time: in_ready is high only while the
// controller is idle. A number request first converts the magnitude to
// decimal in a shift-and-add-3 converter. Each byte is then a load followed
// by two transfers, high nibble then low, and a step that sends nothing
// loads no byte and moves on.
// One nibble is held back inside so that the final one can be marked, and the
// output stage is a register: when out_ready is low the generator stops and
// resumes without loss. A request that causes no nibble produces no item.
// Reset (synchronous, active low) returns to idle and empties the output.
`include "char_lcd_nibble_writer_unit_macros.svh"

module char_lcd_nibble_writer_unit (
  input  logic      clk,
  input  logic      rst_n,
  cln_req_if.sink   in_req,
  cln_nib_if.source out_nib
);

  cln_pkg::dp_cmd_t dcmd;
  cln_pkg::dp_sts_t sts;

  cln_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .in_cmd   (in_req.cmd),
    .sts      (sts),
    .dcmd     (dcmd)
  );

  cln_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dcmd           (dcmd),
    .sts            (sts),
    .in_cmd         (in_req.cmd),
    .in_byte_value  (in_req.byte_value),
    .in_row         (in_req.row),
    .in_column      (in_req.column),
    .in_number      (in_req.number),
    .in_digit_count (in_req.digit_count),
    .out_valid      (out_nib.valid),
    .out_ready      (out_nib.ready),
    .out_reg_select (out_nib.reg_select),
    .out_nibble     (out_nib.nibble),
    .out_last       (out_nib.last)
  );

  // A new request never starts while a nibble of the previous one is held back.
  `CLN_ASSERT_IMPLY(a_accept_hold_empty, clk, rst_n, in_req.valid && in_req.ready, !sts.hold_valid)
  // The generator only advances when the output register can take the held nibble.
  `CLN_ASSERT_IMPLY(a_push_needs_room, clk, rst_n, dcmd.push || dcmd.finish, sts.out_free)
  // Closing a request presents its final nibble, flagged as last.
  `CLN_ASSERT_NEXT(a_finish_marks_last, clk, rst_n, dcmd.finish, out_nib.valid && out_nib.last)

endmodule

### hw/rtl/cln_dp.sv
module cln_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cln_pkg::dp_cmd_t   dcmd,
  output cln_pkg::dp_sts_t   sts,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_byte_value,
  input  logic [2:0]         in_row,
  input  logic [7:0]         in_column,
  input  logic signed [15:0] in_number,
  input  logic [3:0]         in_digit_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_reg_select,
  output logic [3:0]         out_nibble,
  output logic               out_last
);

  logic [1:0]                   req_r;
  logic [7:0]                   bval_r;
  logic [2:0]                   row_r;
  logic [7:0]                   col_r;
  logic                         neg_r;
  logic [2:0]                   didx_r;
  logic                         err_r;
  logic [cln_pkg::MAG_W-1:0]    bin_r;
  logic [cln_pkg::BCD_W-1:0]    bcd_r;
  logic [cln_pkg::BCD_W-1:0]    bcd_adj;
  logic [7:0]                   byte_r;
  logic                         rs_r;
  logic                         hold_valid_r;
  logic                         hold_rs_r;
  logic [3:0]                   hold_nib_r;
  logic                         out_valid_r;
  logic                         out_rs_r;
  logic [3:0]                   out_nib_r;
  logic                         out_last_r;

  logic [cln_pkg::MAG_W-1:0]    mag_in;
  logic [7:0]                   base;
  logic [7:0]                   cursor;
  logic [3:0]                   digit;
  logic [7:0]                   byte_sel;
  logic [3:0]                   new_nib;
  logic                         new_rs;
  logic                         row_ok;
  logic                         out_free;

  assign mag_in = in_number[15] ? (17'h10000 - {1'b0, in_number}) : {1'b0, in_number};
  assign row_ok = (row_r >= 3'd1) && (row_r <= 3'd4);

  always_comb begin
    case (row_r)
      3'd1:    base = cln_pkg::LCD_BASE_R1;
      3'd2:    base = cln_pkg::LCD_BASE_R2;
      3'd3:    base = cln_pkg::LCD_BASE_R3;
      default: base = cln_pkg::LCD_BASE_R4;
    endcase
  end

  // Column counts from one, so the address is base plus column minus one.
  assign cursor = base + col_r + 8'hFF;

  always_comb begin
    case (didx_r)
      3'd1:    digit = bcd_r[3:0];
      3'd2:    digit = bcd_r[7:4];
      3'd3:    digit = bcd_r[11:8];
      3'd4:    digit = bcd_r[15:12];
      3'd5:    digit = bcd_r[19:16];
      default: digit = 4'd0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < cln_pkg::MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    case (dcmd.bsrc)
      cln_pkg::BSRC_INIT:   byte_sel = cln_pkg::init_byte(dcmd.init_idx);
      cln_pkg::BSRC_BYTE:   byte_sel = bval_r;
      cln_pkg::BSRC_CURSOR: byte_sel = cursor;
      cln_pkg::BSRC_HOME:   byte_sel = cln_pkg::CUR_HOME;
      cln_pkg::BSRC_MINUS:  byte_sel = cln_pkg::CH_MINUS;
      cln_pkg::BSRC_DIGIT:  byte_sel = cln_pkg::CH_ZERO + {4'd0, digit};
      default:              byte_sel = cln_pkg::CH_ERR;
    endcase
  end

  always_comb begin
    case (dcmd.nsel)
      cln_pkg::NSEL_HI:   begin new_nib = byte_r[7:4];       new_rs = rs_r; end
      cln_pkg::NSEL_LO:   begin new_nib = byte_r[3:0];       new_rs = rs_r; end
      cln_pkg::NSEL_WAKE: begin new_nib = cln_pkg::NIB_WAKE; new_rs = 1'b0; end
      default:            begin new_nib = cln_pkg::NIB_4BIT; new_rs = 1'b0; end
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  // Request fields, digit conversion and the byte register.
  always_ff @(posedge clk) begin
    if (dcmd.load_in) begin
      req_r  <= in_cmd;
      bval_r <= in_byte_value;
      row_r  <= in_row;
      col_r  <= in_column;
      neg_r  <= in_number[15];
      didx_r <= ((in_digit_count >= 4'd1) && (in_digit_count <= 4'd5))
                ? in_digit_count[2:0] : 3'd0;
      err_r  <= in_digit_count > 4'd5;
      bin_r  <= mag_in;
      bcd_r  <= '0;
    end else begin
      if (dcmd.dd_step) begin
        bcd_r <= {bcd_adj[cln_pkg::BCD_W-2:0], bin_r[cln_pkg::MAG_W-1]};
        bin_r <= {bin_r[cln_pkg::MAG_W-2:0], 1'b0};
      end
      if (dcmd.col_inc) begin
        col_r <= col_r + 8'd1;
      end
      if (dcmd.didx_dec) begin
        didx_r <= didx_r - 3'd1;
      end
    end
    if (dcmd.load_byte) begin
      byte_r <= byte_sel;
      rs_r   <= dcmd.byte_rs;
    end
  end

  // One nibble is held back so that the final one can be flagged as last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (dcmd.push) begin
        hold_valid_r <= 1'b1;
        hold_rs_r    <= new_rs;
        hold_nib_r   <= new_nib;
        if (hold_valid_r) begin
          out_valid_r <= 1'b1;
          out_rs_r    <= hold_rs_r;
          out_nib_r   <= hold_nib_r;
          out_last_r  <= 1'b0;
        end else if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end else if (dcmd.finish) begin
        hold_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
        out_rs_r     <= hold_rs_r;
        out_nib_r    <= hold_nib_r;
        out_last_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.req        = req_r;
    sts.row_ok     = row_ok;
    sts.home_cond  = (row_r == 3'd0) || (col_r == 8'd0);
    sts.neg        = neg_r;
    sts.didx_nz    = didx_r != 3'd0;
    sts.didx_one   = didx_r == 3'd1;
    sts.err_dc     = err_r;
    sts.out_free   = out_free;
    sts.hold_valid = hold_valid_r;
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_nibble     = out_nib_r;
  assign out_last       = out_last_r;

endmodule

### hw/rtl/cln_ctrl.sv
module cln_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  cln_pkg::dp_sts_t sts,
  output cln_pkg::dp_cmd_t dcmd
);

  cln_pkg::state_t state_r, state_nxt;
  cln_pkg::step_t  step_r, step_nxt;
  logic [4:0]      cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cln_pkg::ST_IDLE;
      step_r  <= cln_pkg::STP_DONE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    in_ready       = 1'b0;
    dcmd.load_in   = 1'b0;
    dcmd.dd_step   = 1'b0;
    dcmd.load_byte = 1'b0;
    dcmd.bsrc      = cln_pkg::BSRC_BYTE;
    dcmd.byte_rs   = 1'b0;
    dcmd.init_idx  = cnt_r[2:0];
    dcmd.col_inc   = 1'b0;
    dcmd.didx_dec  = 1'b0;
    dcmd.push      = 1'b0;
    dcmd.nsel      = cln_pkg::NSEL_HI;
    dcmd.finish    = 1'b0;

    case (state_r)
      cln_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dcmd.load_in = 1'b1;
          cnt_nxt      = 5'd0;
          case (in_cmd)
            cln_pkg::REQ_INIT: state_nxt = cln_pkg::ST_INITNIB;
            cln_pkg::REQ_CMD: begin
              state_nxt = cln_pkg::ST_STEP;
              step_nxt  = cln_pkg::STP_CMD;
            end
            cln_pkg::REQ_CHAR: begin
              state_nxt = cln_pkg::ST_STEP;
              step_nxt  = cln_pkg::STP_CUR0;
            end
            default: state_nxt = cln_pkg::ST_CONV;
          endcase
        end
      end

      cln_pkg::ST_CONV: begin
        dcmd.dd_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(cln_pkg::DD_STEPS - 1)) begin
          cnt_nxt   = 5'd0;
          state_nxt = cln_pkg::ST_STEP;
          step_nxt  = cln_pkg::STP_CUR0;
        end
      end

      cln_pkg::ST_INITNIB: begin
        if (sts.out_free) begin
          dcmd.push = 1'b1;
          if (cnt_r == 5'(cln_pkg::WAKE_NIBS)) begin
            dcmd.nsel = cln_pkg::NSEL_4BIT;
            cnt_nxt   = 5'd0;
            state_nxt = cln_pkg::ST_STEP;
            step_nxt  = cln_pkg::STP_INIT;
          end else begin
            dcmd.nsel = cln_pkg::NSEL_WAKE;
            cnt_nxt   = cnt_r + 5'd1;
          end
        end
      end

      cln_pkg::ST_STEP: begin
        case (step_r)
          cln_pkg::STP_INIT: begin
            if (cnt_r < 5'(cln_pkg::INIT_BYTES)) begin
              dcmd.load_byte = 1'b1;
              dcmd.bsrc      = cln_pkg::BSRC_INIT;
              cnt_nxt        = cnt_r + 5'd1;
              state_nxt      = cln_pkg::ST_HI;
            end else begin
              step_nxt = cln_pkg::STP_DONE;
            end
          end
          cln_pkg::STP_CMD: begin
            dcmd.load_byte = 1'b1;
            dcmd.bsrc      = cln_pkg::BSRC_BYTE;
            state_nxt      = cln_pkg::ST_HI;
            step_nxt       = cln_pkg::STP_DONE;
          end
          cln_pkg::STP_CUR0: begin
            if (sts.row_ok) begin
              dcmd.load_byte = 1'b1;
              dcmd.bsrc      = cln_pkg::BSRC_CURSOR;
              state_nxt      = cln_pkg::ST_HI;
            end
            if (sts.req == cln_pkg::REQ_CHAR) begin
              step_nxt = cln_pkg::STP_CHAR;
            end else if (sts.neg) begin
              step_nxt = cln_pkg::STP_NEGCUR;
            end else begin
              step_nxt = cln_pkg::STP_HOME;
            end
          end
          cln_pkg::STP_CHAR: begin
            dcmd.load_byte = 1'b1;
            dcmd.bsrc      = cln_pkg::BSRC_BYTE;
            dcmd.byte_rs   = 1'b1;
            state_nxt      = cln_pkg::ST_HI;
            step_nxt       = cln_pkg::STP_DONE;
          end
          cln_pkg::STP_NEGCUR: begin
            if (sts.row_ok) begin
              dcmd.load_byte = 1'b1;
              dcmd.bsrc      = cln_pkg::BSRC_CURSOR;
              state_nxt      = cln_pkg::ST_HI;
            end
            step_nxt = cln_pkg::STP_NEGCH;
          end
          cln_pkg::STP_NEGCH: begin
            dcmd.load_byte = 1'b1;
            dcmd.bsrc      = cln_pkg::BSRC_MINUS;
            dcmd.byte_rs   = 1'b1;
            dcmd.col_inc   = 1'b1;
            state_nxt      = cln_pkg::ST_HI;
            step_nxt       = cln_pkg::STP_HOME;
          end
          cln_pkg::STP_HOME: begin
            if (sts.home_cond) begin
              dcmd.load_byte = 1'b1;
              dcmd.bsrc      = cln_pkg::BSRC_HOME;
              state_nxt      = cln_pkg::ST_HI;
            end else if (sts.row_ok) begin
              dcmd.load_byte = 1'b1;
              dcmd.bsrc      = cln_pkg::BSRC_CURSOR;
              state_nxt      = cln_pkg::ST_HI;
            end
            if (sts.didx_nz) begin
              step_nxt = cln_pkg::STP_DCUR;
            end else if (sts.err_dc) begin
              step_nxt = cln_pkg::STP_ECUR;
            end else begin
              step_nxt = cln_pkg::STP_DONE;
            end
          end
          cln_pkg::STP_DCUR: begin
            if (sts.row_ok) begin
              dcmd.load_byte = 1'b1;
              dcmd.bsrc      = cln_pkg::BSRC_CURSOR;
              state_nxt      = cln_pkg::ST_HI;
            end
            step_nxt = cln_pkg::STP_DCH;
          end
          cln_pkg::STP_DCH: begin
            dcmd.load_byte = 1'b1;
            dcmd.bsrc      = cln_pkg::BSRC_DIGIT;
            dcmd.byte_rs   = 1'b1;
            dcmd.col_inc   = 1'b1;
            dcmd.didx_dec  = 1'b1;
            state_nxt      = cln_pkg::ST_HI;
            step_nxt       = sts.didx_one ? cln_pkg::STP_DONE : cln_pkg::STP_DCUR;
          end
          cln_pkg::STP_ECUR: begin
            if (sts.row_ok) begin
              dcmd.load_byte = 1'b1;
              dcmd.bsrc      = cln_pkg::BSRC_CURSOR;
              state_nxt      = cln_pkg::ST_HI;
            end
            step_nxt = cln_pkg::STP_ECH;
          end
          cln_pkg::STP_ECH: begin
            dcmd.load_byte = 1'b1;
            dcmd.bsrc      = cln_pkg::BSRC_ERR;
            dcmd.byte_rs   = 1'b1;
            state_nxt      = cln_pkg::ST_HI;
            step_nxt       = cln_pkg::STP_DONE;
          end
          default: begin
            state_nxt = cln_pkg::ST_FINISH;
          end
        endcase
      end

      cln_pkg::ST_HI: begin
        if (sts.out_free) begin
          dcmd.push = 1'b1;
          dcmd.nsel = cln_pkg::NSEL_HI;
          state_nxt = cln_pkg::ST_LO;
        end
      end

      cln_pkg::ST_LO: begin
        if (sts.out_free) begin
          dcmd.push = 1'b1;
          dcmd.nsel = cln_pkg::NSEL_LO;
          state_nxt = cln_pkg::ST_STEP;
        end
      end

      cln_pkg::ST_FINISH: begin
        // A request that produced nothing ends without touching the output.
        if (!sts.hold_valid) begin
          state_nxt = cln_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          dcmd.finish = 1'b1;
          state_nxt   = cln_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cln_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### tb/char_lcd_nibble_writer_unit_tb.sv
`timescale 1ns / 100ps

module char_lcd_nibble_writer_unit_tb;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;
  localparam logic [7:0] INIT_BYTES_SEQ [5] = '{8'h28, 8'h01, 8'h06, 8'h0E, 8'h80};

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         byte_value;
    logic [2:0]         row;
    logic [7:0]         column;
    logic signed [15:0] number;
    logic [3:0]         digit_count;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } lcd_xfer_t;

  logic clk = 1'b0;
  logic rst_n;
  bit idle_enable = 1'b1;
  int mismatch_count = 0;
  int stall_left;
  lcd_xfer_t nibbles_due[$];

  cln_req_if in_req();
  cln_nib_if out_nib();

  char_lcd_nibble_writer_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_nib (out_nib)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void push_nibble(input logic rs, input logic [3:0] nib);
    lcd_xfer_t x;
    x.rs = rs;
    x.nib = nib;
    x.last = 1'b0;
    nibbles_due.push_back(x);
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b);
    push_nibble(rs, b[7:4]);
    push_nibble(rs, b[3:0]);
  endfunction

  // Rows outside 1..4 leave the cursor where it is and send nothing.
  function automatic void push_cursor(input logic [2:0] row, input logic [7:0] col);
    logic [7:0] base;
    case (row)
      3'd1: base = cln_pkg::LCD_BASE_R1;
      3'd2: base = cln_pkg::LCD_BASE_R2;
      3'd3: base = cln_pkg::LCD_BASE_R3;
      3'd4: base = cln_pkg::LCD_BASE_R4;
      default: return;
    endcase
    push_byte(RS_CMD, 8'(base + col - 8'd1));
  endfunction

  function automatic void push_char(input logic [2:0] row, input logic [7:0] col,
                                    input logic [7:0] ch);
    push_cursor(row, col);
    push_byte(RS_DATA, ch);
  endfunction

  function automatic void predict_transfers(input lcd_req_t r);
    int first;
    logic [7:0] col;
    logic [16:0] mag;
    int unsigned div;
    bit run;
    first = nibbles_due.size();
    col = r.column;
    run = 1'b0;
    case (r.cmd)
      cln_pkg::REQ_INIT: begin
        repeat (cln_pkg::WAKE_NIBS) push_nibble(RS_CMD, cln_pkg::NIB_WAKE);
        push_nibble(RS_CMD, cln_pkg::NIB_4BIT);
        foreach (INIT_BYTES_SEQ[i]) push_byte(RS_CMD, INIT_BYTES_SEQ[i]);
      end
      cln_pkg::REQ_CMD: begin
        push_byte(RS_CMD, r.byte_value);
      end
      cln_pkg::REQ_CHAR: begin
        push_char(r.row, col, r.byte_value);
      end
      default: begin
        push_cursor(r.row, col);
        if (r.number[15]) begin
          mag = 17'h10000 - {1'b0, r.number};
          push_char(r.row, col, cln_pkg::CH_MINUS);
          col++;
        end else begin
          mag = {1'b0, r.number};
        end
        if (r.row == 3'd0 || col == 8'd0) push_byte(RS_CMD, cln_pkg::CUR_HOME);
        else push_cursor(r.row, col);
        // The leading digit of a five-digit field is not reduced modulo ten.
        for (int pos = cln_pkg::MAX_DIGITS; pos >= 1; pos--) begin
          if (r.digit_count == pos || run) begin
            div = 1;
            repeat (pos - 1) div *= 10;
            if (pos == cln_pkg::MAX_DIGITS)
              push_char(r.row, col, 8'(mag / div + cln_pkg::CH_ZERO));
            else
              push_char(r.row, col, 8'((mag / div) % 10 + cln_pkg::CH_ZERO));
            col++;
            run = 1'b1;
          end
        end
        if (r.digit_count > cln_pkg::MAX_DIGITS) push_char(r.row, col, cln_pkg::CH_ERR);
      end
    endcase
    if (nibbles_due.size() > first) nibbles_due[nibbles_due.size() - 1].last = 1'b1;
  endfunction

  function automatic lcd_req_t req_of(input logic [1:0] cmd, input logic [7:0] bv,
                                      input logic [2:0] row, input logic [7:0] col,
                                      input logic signed [15:0] num, input logic [3:0] dc);
    lcd_req_t r;
    r.cmd = cmd;
    r.byte_value = bv;
    r.row = row;
    r.column = col;
    r.number = num;
    r.digit_count = dc;
    return r;
  endfunction

  task automatic send_request(input lcd_req_t r);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.cmd         <= r.cmd;
    in_req.byte_value  <= r.byte_value;
    in_req.row         <= r.row;
    in_req.column      <= r.column;
    in_req.number      <= r.number;
    in_req.digit_count <= r.digit_count;
    predict_transfers(r);
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_req.valid <= 1'b0;
    while (nibbles_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_init_sequence();
    send_request(req_of(cln_pkg::REQ_INIT, 8'h00, 3'd0, 8'd0, 16'sd0, 4'd0));
  endtask

  task automatic test_command_bytes();
    send_request(req_of(cln_pkg::REQ_CMD, 8'h00, 3'd7, 8'd255, -16'sd1, 4'd15));
    send_request(req_of(cln_pkg::REQ_CMD, 8'hFF, 3'd0, 8'd0, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CMD, 8'h5A, 3'd1, 8'd1, 16'sd5, 4'd1));
  endtask

  // Every row code, including the ones that skip cursor positioning.
  task automatic test_char_positions();
    send_request(req_of(cln_pkg::REQ_CHAR, 8'h41, 3'd0, 8'd1, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'h00, 3'd1, 8'd1, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'hFF, 3'd2, 8'd0, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'h7E, 3'd3, 8'd255, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'h30, 3'd4, 8'd20, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'h81, 3'd5, 8'd3, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'hA5, 3'd6, 8'd128, 16'sd0, 4'd0));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'h5A, 3'd7, 8'd0, 16'sd0, 4'd0));
  endtask

  task automatic test_number_display();
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd1, 8'd1, -16'sd32768, 4'd5));
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd4, 8'd20, 16'sd32767, 4'd5));
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd2, 8'd1, 16'sd0, 4'd1));
    // A negative value at column 255 wraps the column to zero, so home is sent.
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd3, 8'd255, -16'sd1, 4'd2));
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd1, 8'd3, 16'sd12345, 4'd3));
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd0, 8'd5, 16'sd99, 4'd4));
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd7, 8'd0, -16'sd5, 4'd6));
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd2, 8'd10, 16'sd100, 4'd15));
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd1, 8'd7, 16'sd42, 4'd0));
    // No cursor, no sign and no digits: this request yields no item at all.
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd5, 8'd3, 16'sd7, 4'd0));
  endtask

  task automatic test_drain_pause();
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd4, 8'd2, -16'sd9876, 4'd5));
    send_request(req_of(cln_pkg::REQ_CHAR, 8'h3F, 3'd2, 8'd16, 16'sd0, 4'd0));
    wait_for_drain();
    send_request(req_of(cln_pkg::REQ_NUM, 8'h00, 3'd6, 8'd4, 16'sd3, 4'd0));
    send_request(req_of(cln_pkg::REQ_CMD, 8'h0C, 3'd0, 8'd0, 16'sd0, 4'd0));
  endtask

  // Mostly well-formed positions and digit counts, with some of everything else.
  task automatic test_random_traffic(input int count);
    lcd_req_t r;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      if (k == 0) r.cmd = cln_pkg::REQ_INIT;
      else if (k <= 2) r.cmd = cln_pkg::REQ_CMD;
      else if (k <= 5) r.cmd = cln_pkg::REQ_CHAR;
      else r.cmd = cln_pkg::REQ_NUM;
      r.byte_value = 8'($urandom_range(0, 255));
      r.row = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(1, 4));
      r.column = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(1, 20));
      r.number = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 2000) - 1000);
      r.digit_count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 5));
      send_request(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_nib.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_nib.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_nib.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_nib.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lcd_xfer_t due;
    if (rst_n && out_nib.valid && out_nib.ready) begin
      if (nibbles_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item rs=%0b nibble=%h last=%0b",
                                  out_nib.reg_select, out_nib.nibble, out_nib.last));
      end else begin
        due = nibbles_due.pop_front();
        if (out_nib.reg_select !== due.rs)
          report_mismatch($sformatf("reg_select %0b, expected %0b", out_nib.reg_select, due.rs));
        if (out_nib.nibble !== due.nib)
          report_mismatch($sformatf("nibble %h, expected %h", out_nib.nibble, due.nib));
        if (out_nib.last !== due.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_nib.last, due.last));
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.cmd         <= cln_pkg::REQ_INIT;
    in_req.byte_value  <= 8'h00;
    in_req.row         <= 3'd0;
    in_req.column      <= 8'd0;
    in_req.number      <= 16'sd0;
    in_req.digit_count <= 4'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_init_sequence();
    test_command_bytes();
    test_char_positions();
    test_number_display();
    test_drain_pause();
    test_random_traffic(105);
    idle_enable = 1'b0;
    test_random_traffic(20);

    wait_for_drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && nibbles_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
